/* hw/rtl/vnpg_pkg.sv */
package vnpg_pkg;

	// Hash and blend constants.
	localparam logic [31:0] NOISE_ADD  = 32'd30987;
	localparam logic [31:0] NOISE_MUL  = 32'd29893;
	localparam logic [31:0] NOISE_MOD  = 32'd104532;
	localparam logic [31:0] STEP_X     = 32'd9;
	localparam logic [31:0] STEP_Y     = 32'd5;

	// Field and datapath widths.
	localparam int COORD_W = 16;
	localparam int SIZE_W  = 9;
	localparam int CELL_W  = 18;
	localparam int HASH_W  = 17;
	localparam int WGT_W   = 18;
	localparam int OUT_W   = 8;

	// Number of compare and subtract steps in the hash remainder chain.
	localparam int MOD_STEPS = 15;

	// Latency of the corner hash unit in cycles.
	localparam int HASH_LAT = 3 + MOD_STEPS;

endpackage

/* hw/rtl/vnpg_div_cell.sv */
module vnpg_div_cell #(
	parameter int W  = 8,
	parameter int QW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  rem_i,
	input  logic [W-1:0]  dvs_i,
	input  logic [QW-1:0] quo_i,
	output logic [W-1:0]  rem_o,
	output logic [QW-1:0] quo_o
);

	logic          ge;
	logic [QW:0]   quo_next;
	logic [W-1:0]  rem_q;
	logic [QW-1:0] quo_q;

	// One restoring step: subtract the shifted divisor when it fits.
	assign ge       = (rem_i >= dvs_i);
	assign quo_next = {quo_i, ge};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? (rem_i - dvs_i) : rem_i;
			quo_q <= quo_next[QW-1:0];
		end
	end

	assign rem_o = rem_q;
	assign quo_o = quo_q;

endmodule

/* hw/rtl/vnpg_hash.sv */
module vnpg_hash
	import vnpg_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [31:0]       s,
	output logic [HASH_W-1:0] h
);

	logic [31:0] sq_s1;
	logic [31:0] u_s2;
	logic [31:0] mag_s3;
	logic [31:0] rem [MOD_STEPS+1];

	// Square, scale and fold the corner index; all products wrap to 32 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1  <= s * s;
			u_s2   <= NOISE_ADD - NOISE_MUL * sq_s1;
			mag_s3 <= u_s2[31] ? (32'd0 - u_s2) : u_s2;
		end
	end

	// The remainder of the magnitude equals the magnitude of the truncated remainder.
	assign rem[0] = mag_s3;

	for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
		localparam int SH = MOD_STEPS - 1 - j;
		vnpg_div_cell #(.W(32), .QW(1)) u_cell (
			.clk   (clk),
			.en    (en),
			.rem_i (rem[j]),
			.dvs_i (NOISE_MOD << SH),
			.quo_i (1'b0),
			.rem_o (rem[j+1]),
			.quo_o ()
		);
	end

	assign h = rem[MOD_STEPS][HASH_W-1:0];

endmodule

/* hw/rtl/value_noise_pixel_generator.sv */
// Channel   Direction  Handshake             Payload
// pixel in  input      in_valid / in_ready   coord_x, coord_y
// noise out output     out_valid / out_ready intensity
// config    input      cfg_we                cell_size
//
// One item enters per clock while the output is not stalled.
// The pipeline holds three restoring divider chains in series:
// 16 cells for the cell index, 15 for the hash remainder, 8 for the blend.
// Reset clears the valid pipeline and sets the cell size to 1.
// A stalled output freezes the whole pipeline; ready drops only while the
// last stage holds an item that is not taken.
module value_noise_pixel_generator
	import vnpg_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [SIZE_W-1:0]         cell_size,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [OUT_W-1:0]          intensity
);

	localparam int LAT = 48;

	logic                     en;
	logic [LAT-1:0]           vld_q;
	logic [SIZE_W-1:0]        sz_q;
	logic [17:0]              szsq_q;
	logic [43:0]              den_q;

	logic                     sgn_x_s1, sgn_y_s1;
	logic [COORD_W-1:0]       mag_x_s1, mag_y_s1;
	logic [24:0]              rem_x [COORD_W+1];
	logic [24:0]              rem_y [COORD_W+1];
	logic [COORD_W-1:0]       quo_x [COORD_W+1];
	logic [COORD_W-1:0]       quo_y [COORD_W+1];
	logic [1:0]               sgn_dly_q [COORD_W+1];

	logic [SIZE_W-1:0]        r_x, r_y;
	logic [CELL_W-1:0]        q_x, q_y;
	logic signed [CELL_W-1:0] cx_s18, cy_s18;
	logic [SIZE_W-1:0]        a_s18, b_s18;

	logic signed [31:0]       cx32, cy32, s00;
	logic [SIZE_W-1:0]        sa, sb;
	logic [31:0]              s_s19 [4];
	logic [WGT_W-1:0]         w_s19 [4];
	logic [WGT_W-1:0]         w_dly_q [HASH_LAT+1][4];
	logic [HASH_W-1:0]        h [4];

	logic [34:0]              p_s38 [4];
	logic [36:0]              sum_s39;
	logic [43:0]              num_s40;
	logic [43:0]              rem_f [OUT_W+1];
	logic [OUT_W-1:0]         quo_f [OUT_W+1];

	// Pipeline advance and handshake.
	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Cell size register; zero is stored as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sz_q <= SIZE_W'(1);
		end else if (cfg_we) begin
			sz_q <= (cell_size == '0) ? SIZE_W'(1) : cell_size;
		end
	end

	// Blend denominator, recomputed every cycle from the cell size.
	always_ff @(posedge clk) begin
		szsq_q <= 18'(sz_q) * 18'(sz_q);
		den_q  <= 44'(szsq_q) * 44'(NOISE_MOD);
	end

	// Split the coordinates into sign and magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			sgn_x_s1 <= coord_x[COORD_W-1];
			sgn_y_s1 <= coord_y[COORD_W-1];
			mag_x_s1 <= coord_x[COORD_W-1] ? COORD_W'(-coord_x) : coord_x;
			mag_y_s1 <= coord_y[COORD_W-1] ? COORD_W'(-coord_y) : coord_y;
		end
	end

	// Restoring divider chains for the magnitudes over the cell size.
	assign rem_x[0]     = 25'(mag_x_s1);
	assign rem_y[0]     = 25'(mag_y_s1);
	assign quo_x[0]     = '0;
	assign quo_y[0]     = '0;
	assign sgn_dly_q[0] = {sgn_y_s1, sgn_x_s1};

	for (genvar i = 0; i < COORD_W; i++) begin : g_cdiv
		localparam int SH = COORD_W - 1 - i;
		vnpg_div_cell #(.W(25), .QW(COORD_W)) u_cell_x (
			.clk   (clk),
			.en    (en),
			.rem_i (rem_x[i]),
			.dvs_i (25'(sz_q) << SH),
			.quo_i (quo_x[i]),
			.rem_o (rem_x[i+1]),
			.quo_o (quo_x[i+1])
		);
		vnpg_div_cell #(.W(25), .QW(COORD_W)) u_cell_y (
			.clk   (clk),
			.en    (en),
			.rem_i (rem_y[i]),
			.dvs_i (25'(sz_q) << SH),
			.quo_i (quo_y[i]),
			.rem_o (rem_y[i+1]),
			.quo_o (quo_y[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				sgn_dly_q[i+1] <= sgn_dly_q[i];
			end
		end
	end

	// Floor convention: a negative point with a remainder moves to the cell below.
	assign r_x = rem_x[COORD_W][SIZE_W-1:0];
	assign r_y = rem_y[COORD_W][SIZE_W-1:0];
	assign q_x = CELL_W'(quo_x[COORD_W]);
	assign q_y = CELL_W'(quo_y[COORD_W]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (sgn_dly_q[COORD_W][0] && (r_x != '0)) begin
				cx_s18 <= ~q_x;
				a_s18  <= sz_q - r_x;
			end else if (sgn_dly_q[COORD_W][0]) begin
				cx_s18 <= -q_x;
				a_s18  <= '0;
			end else begin
				cx_s18 <= q_x;
				a_s18  <= r_x;
			end
			if (sgn_dly_q[COORD_W][1] && (r_y != '0)) begin
				cy_s18 <= ~q_y;
				b_s18  <= sz_q - r_y;
			end else if (sgn_dly_q[COORD_W][1]) begin
				cy_s18 <= -q_y;
				b_s18  <= '0;
			end else begin
				cy_s18 <= q_y;
				b_s18  <= r_y;
			end
		end
	end

	// Corner indices and bilinear weights.
	assign cx32 = 32'(cx_s18);
	assign cy32 = 32'(cy_s18);
	assign s00  = (cx32 <<< 3) + cx32 + (cy32 <<< 2) + cy32;
	assign sa   = sz_q - a_s18;
	assign sb   = sz_q - b_s18;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s19[0] <= s00;
			s_s19[1] <= s00 + STEP_X;
			s_s19[2] <= s00 + STEP_Y;
			s_s19[3] <= s00 + STEP_X + STEP_Y;
			w_s19[0] <= WGT_W'(sa) * WGT_W'(sb);
			w_s19[1] <= WGT_W'(a_s18) * WGT_W'(sb);
			w_s19[2] <= WGT_W'(sa) * WGT_W'(b_s18);
			w_s19[3] <= WGT_W'(a_s18) * WGT_W'(b_s18);
		end
	end

	// Corner hashes, with the weights delayed to meet them.
	for (genvar c = 0; c < 4; c++) begin : g_corner
		vnpg_hash u_hash (
			.clk (clk),
			.en  (en),
			.s   (s_s19[c]),
			.h   (h[c])
		);
		assign w_dly_q[0][c] = w_s19[c];
		for (genvar k = 0; k < HASH_LAT; k++) begin : g_wdly
			always_ff @(posedge clk) begin
				if (en) begin
					w_dly_q[k+1][c] <= w_dly_q[k][c];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				p_s38[c] <= 35'(w_dly_q[HASH_LAT][c]) * 35'(h[c]);
			end
		end
	end

	// Sum of weighted corners, then the full-scale factor.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s39 <= 37'(p_s38[0]) + 37'(p_s38[1]) + 37'(p_s38[2]) + 37'(p_s38[3]);
			num_s40 <= (44'(sum_s39) << 8) - 44'(sum_s39);
		end
	end

	// Final division; the quotient fits in the output width.
	assign rem_f[0] = num_s40;
	assign quo_f[0] = '0;

	for (genvar k = 0; k < OUT_W; k++) begin : g_fdiv
		localparam int SH = OUT_W - 1 - k;
		vnpg_div_cell #(.W(44), .QW(OUT_W)) u_cell_f (
			.clk   (clk),
			.en    (en),
			.rem_i (rem_f[k]),
			.dvs_i (den_q << SH),
			.quo_i (quo_f[k]),
			.rem_o (rem_f[k+1]),
			.quo_o (quo_f[k+1])
		);
	end

	assign intensity = quo_f[OUT_W];

	// The cell offsets lie inside the cell.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[17] |-> (a_s18 < sz_q) && (b_s18 < sz_q))
		else $error("cell offset out of range");

	// The first and last corner hashes are proper remainders.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[36] |-> (32'(h[0]) < NOISE_MOD) && (32'(h[3]) < NOISE_MOD))
		else $error("corner hash out of range");

	// The blend never reaches full scale.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (intensity != 8'hFF))
		else $error("intensity overflow");

endmodule
